[hdl/zpc_pkg.sv]
`timescale 1ns / 1ps

package zpc_pkg;

   // Fixed field widths of the channels and frame counters, and the rounding and clip constants.
   localparam int PIXEL_W       = 16;
   localparam int COEF_W        = 16;
   localparam int COEF_IDX_W    = 8;
   localparam int DIM_W         = 11;
   localparam int KDIM_W        = 4;
   localparam int IN_COUNT_W    = 21;
   localparam int OUT_COUNT_W   = 20;
   localparam int CSR_ADDR_W    = 8;
   localparam int CSR_DATA_W    = 16;
   localparam int FRAC_BITS     = 14;
   localparam int ROUND_HALF    = 8192;
   localparam int PIX_MAX       = 32767;
   localparam int PIX_MIN       = -32768;

   typedef enum logic [1:0] {
      MODE_COEF  = 2'd0,
      MODE_PIXEL = 2'd1,
      MODE_FLUSH = 2'd2,
      MODE_SPARE = 2'd3
   } mode_type;

   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH   = 8'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT  = 8'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_WIDTH  = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_KERNEL_HEIGHT = 8'd3;

   // Tag that follows one kernel tap through the multiply-accumulate pipe.
   typedef struct packed {
      logic valid;
      logic in_image;
      logic last;
   } tap_tag_type;

endpackage

[hdl/zpc_if.sv]
`timescale 1ns / 1ps

interface zpc_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [1:0]                              mode;
   logic [zpc_pkg::COEF_IDX_W-1:0]          coef_index;
   logic signed [zpc_pkg::COEF_W-1:0]       coef_value;
   logic signed [zpc_pkg::PIXEL_W-1:0]      pixel_value;
   modport source (output valid, mode, coef_index, coef_value, pixel_value, input ready);
   modport sink   (input valid, mode, coef_index, coef_value, pixel_value, output ready);
endinterface

interface zpc_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [zpc_pkg::PIXEL_W-1:0]      filtered_value;
   logic                                    saturated;
   logic                                    last_of_frame;
   modport source (output valid, filtered_value, saturated, last_of_frame, input ready);
   modport sink   (input valid, filtered_value, saturated, last_of_frame, output ready);
endinterface

interface zpc_csr_if;
   logic                                    valid;
   logic                                    ready;
   logic [zpc_pkg::CSR_ADDR_W-1:0]          index;
   logic [zpc_pkg::CSR_DATA_W-1:0]          data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

[hdl/zpc_ram.sv]
`timescale 1ns / 1ps

module zpc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/zero_padded_2d_convolution.sv]
`timescale 1ns / 1ps

// Streaming 2D convolution with zero padding.
// Words arrive on req_bus: mode 0 loads one Q1.14 kernel coefficient, mode 1
// carries one raster pixel, mode 2 is an end-of-frame flush tick that counts
// as a zero pixel, and mode 3 is dropped. Results leave on rsp_bus, one word
// per output pixel in raster order, flagged when saturated and on the last
// pixel of the frame. csr_bus writes the image and kernel geometry; it is
// always ready and is meant to be written while the block is idle.
// A coefficient word, a spare word or a pixel that does not yet complete a
// kernel window is taken and the block stays idle. For a pixel that
// releases an output, a bit-serial restoring divide of the output count by
// the image width finds the row and column of the output pixel, while a
// pointer that follows the output count gives its line store slot; then a
// single multiply-accumulate unit walks the kernel one tap per cycle, reading
// the line store and the coefficient store. The result sits in an output
// register; the block takes no word while it works out an output, goes on
// accepting words while a result waits, and holds a second result until
// the first is taken. Reset clears the counters, pointers and output valid
// flag and sets the geometry (1024 by 1024 image, 1 by 1 kernel).

module zero_padded_2d_convolution #(
   parameter int MAX_WIDTH         = 1024,
   parameter int MAX_HEIGHT        = 1024,
   parameter int MAX_KERNEL_WIDTH  = 15,
   parameter int MAX_KERNEL_HEIGHT = 15
) (
   input logic        clock,
   input logic        reset,
   zpc_req_if.sink    req_bus,
   zpc_rsp_if.source  rsp_bus,
   zpc_csr_if.sink    csr_bus
);

   localparam int COEF_DEPTH = MAX_KERNEL_WIDTH * MAX_KERNEL_HEIGHT;
   localparam int COEF_AW    = (COEF_DEPTH > 1) ? $clog2(COEF_DEPTH) : 1;
   localparam int LINE_DEPTH =
      2 * ((MAX_KERNEL_HEIGHT / 2) * MAX_WIDTH + MAX_KERNEL_WIDTH / 2) + 1;
   localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int WW         = $clog2(MAX_WIDTH + 1);
   localparam int HW         = $clog2(MAX_HEIGHT + 1);
   localparam int KWW        = $clog2(MAX_KERNEL_WIDTH + 1);
   localparam int KHW        = $clog2(MAX_KERNEL_HEIGHT + 1);
   localparam int NW         = WW + HW;
   localparam int POS_W      = zpc_pkg::OUT_COUNT_W + 2;
   localparam int PROD_W     = 2 * zpc_pkg::PIXEL_W;
   localparam int SUM_W      = PROD_W + $clog2(COEF_DEPTH + 1);
   localparam int RES_W      = SUM_W - zpc_pkg::FRAC_BITS;
   localparam int DIV_STEPS  = zpc_pkg::OUT_COUNT_W;
   localparam int DCW        = $clog2(DIV_STEPS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_DIV, S_SETUP, S_MAC, S_DRAIN, S_FIN
   } state_type;

   state_type state_ff;

   logic [zpc_pkg::DIM_W-1:0]       image_width_ff, image_height_ff;
   logic [zpc_pkg::KDIM_W-1:0]      kernel_width_ff, kernel_height_ff;
   logic [zpc_pkg::IN_COUNT_W-1:0]  input_count_ff, input_count_in;
   logic [zpc_pkg::OUT_COUNT_W-1:0] output_count_ff;
   logic [LINE_AW-1:0]              wr_ptr_ff;
   // Line store slot of the next output pixel.
   logic [LINE_AW-1:0]              rd_ptr_ff;

   // Effective geometry after clamping to the supported range.
   logic [WW-1:0]      w_eff;
   logic [HW-1:0]      h_eff;
   logic [KWW-1:0]     kw_eff, kw_half;
   logic [KHW-1:0]     kh_eff, kh_half;
   logic [NW-1:0]      n_total;
   logic [LINE_AW-1:0] lag;

   logic req_fire, emit, frame_last;

   // Divider registers.
   logic [zpc_pkg::OUT_COUNT_W-1:0] dvd_ff, quo_ff;
   logic [WW-1:0]                   remw_ff, remw_in;
   logic [DCW-1:0]                  div_cnt_ff;
   logic [WW:0]                     div_tw;
   logic                            div_qbit;

   // Tap sequencer.
   logic signed [POS_W-1:0] rr_ff, cc_ff, c0_ff;
   logic [KHW-1:0]          i_ff;
   logic [KWW-1:0]          j_ff;
   logic [LINE_AW-1:0]      tap_addr_ff, row_ff, row_next, col_next;
   logic [LINE_AW:0]        row_sum, col_sum, start_sum;
   logic [LINE_AW-1:0]      start_addr;
   logic [COEF_AW-1:0]      coef_addr_ff;
   logic                    tap_in_image, tap_last;

   // Multiply-accumulate pipe.
   zpc_pkg::tap_tag_type        p1_ff, p1_in, p2_ff;
   logic [zpc_pkg::PIXEL_W-1:0] line_rd, coef_rd;
   logic signed [PROD_W-1:0]    product_ff;
   logic signed [SUM_W-1:0]     acc_ff, biased;
   logic signed [RES_W-1:0]     rounded;

   // Output register.
   logic                               rsp_valid_ff, rsp_valid_in, fin_load;
   logic signed [zpc_pkg::PIXEL_W-1:0] filtered_ff, filtered_in;
   logic                               saturated_ff, saturated_in;
   logic                               last_ff;

   logic                               line_we, coef_we;
   logic [zpc_pkg::PIXEL_W-1:0]        line_wd;

   always_comb begin
      if (image_width_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(image_height_ff) > MAX_HEIGHT) begin
         h_eff = HW'(MAX_HEIGHT);
      end else begin
         h_eff = HW'(image_height_ff);
      end
      if (kernel_width_ff == '0) begin
         kw_eff = KWW'(1);
      end else if (32'(kernel_width_ff) > MAX_KERNEL_WIDTH) begin
         kw_eff = KWW'(MAX_KERNEL_WIDTH);
      end else begin
         kw_eff = KWW'(kernel_width_ff);
      end
      if (kernel_height_ff == '0) begin
         kh_eff = KHW'(1);
      end else if (32'(kernel_height_ff) > MAX_KERNEL_HEIGHT) begin
         kh_eff = KHW'(MAX_KERNEL_HEIGHT);
      end else begin
         kh_eff = KHW'(kernel_height_ff);
      end
   end

   assign kw_half = kw_eff >> 1;
   assign kh_half = kh_eff >> 1;
   assign n_total = NW'(w_eff) * NW'(h_eff);
   assign lag     = LINE_AW'(32'(kh_half) * 32'(w_eff) + 32'(kw_half));

   assign req_bus.ready  = (state_ff == S_IDLE);
   assign csr_bus.ready  = 1'b1;
   assign req_fire       = req_bus.valid && req_bus.ready;
   assign input_count_in = input_count_ff + 1'b1;
   // An output is due once its whole window, up to the lag, has arrived.
   assign emit = (32'(output_count_ff) + 32'(lag)) < 32'(input_count_in);
   assign frame_last = (32'(output_count_ff) + 32'd1) >= 32'(n_total);

   // Store writes happen only on accepted words.
   assign line_we = req_fire && (req_bus.mode == zpc_pkg::MODE_PIXEL ||
                                 req_bus.mode == zpc_pkg::MODE_FLUSH);
   assign line_wd = (req_bus.mode == zpc_pkg::MODE_PIXEL) ? req_bus.pixel_value : '0;
   assign coef_we = req_fire && (req_bus.mode == zpc_pkg::MODE_COEF) &&
                    (32'(req_bus.coef_index) < COEF_DEPTH);

   zpc_ram #(.WIDTH(zpc_pkg::PIXEL_W), .DEPTH(LINE_DEPTH)) u_line_ram (
      .clock   (clock),
      .wr_en   (line_we),
      .wr_addr (wr_ptr_ff),
      .wr_data (line_wd),
      .rd_addr (tap_addr_ff),
      .rd_data (line_rd)
   );

   zpc_ram #(.WIDTH(zpc_pkg::COEF_W), .DEPTH(COEF_DEPTH)) u_coef_ram (
      .clock   (clock),
      .wr_en   (coef_we),
      .wr_addr (COEF_AW'(req_bus.coef_index)),
      .wr_data (req_bus.coef_value),
      .rd_addr (coef_addr_ff),
      .rd_data (coef_rd)
   );

   // One restoring step of the divide by the image width.
   always_comb begin
      div_tw   = {remw_ff, dvd_ff[zpc_pkg::OUT_COUNT_W-1]};
      div_qbit = (div_tw >= (WW+1)'(w_eff));
      remw_in  = div_qbit ? WW'(div_tw - (WW+1)'(w_eff)) : WW'(div_tw);
   end

   // Line store addresses wrap modulo its depth; each step is one compare.
   always_comb begin
      start_sum  = (LINE_AW+1)'(rd_ptr_ff) + (LINE_AW+1)'(LINE_DEPTH - 32'(lag));
      start_addr = (32'(start_sum) >= LINE_DEPTH) ? LINE_AW'(32'(start_sum) - LINE_DEPTH)
                                                  : LINE_AW'(start_sum);
      row_sum    = (LINE_AW+1)'(row_ff) + (LINE_AW+1)'(w_eff);
      row_next   = (32'(row_sum) >= LINE_DEPTH) ? LINE_AW'(32'(row_sum) - LINE_DEPTH)
                                                : LINE_AW'(row_sum);
      col_sum    = (LINE_AW+1)'(tap_addr_ff) + 1'b1;
      col_next   = (32'(col_sum) >= LINE_DEPTH) ? '0 : LINE_AW'(col_sum);
   end

   assign tap_in_image = !rr_ff[POS_W-1] && (rr_ff < $signed(POS_W'(h_eff))) &&
                         !cc_ff[POS_W-1] && (cc_ff < $signed(POS_W'(w_eff)));
   assign tap_last     = (i_ff == kh_eff - 1'b1) && (j_ff == kw_eff - 1'b1);

   // A tap enters the pipe on every cycle of the kernel walk.
   always_comb begin
      p1_in = '0;
      if (state_ff == S_MAC) begin
         p1_in = '{valid: 1'b1, in_image: tap_in_image, last: tap_last};
      end
   end

   // The output register loads when the sum is done and the slot is free.
   assign fin_load     = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_bus.ready);
   assign rsp_valid_in = fin_load || (rsp_valid_ff && !rsp_bus.ready);

   // Round half up by floor shift, then clip to the pixel range.
   always_comb begin
      biased  = acc_ff + SUM_W'(zpc_pkg::ROUND_HALF);
      rounded = RES_W'(biased >>> zpc_pkg::FRAC_BITS);
      if (rounded > $signed(RES_W'(zpc_pkg::PIX_MAX))) begin
         filtered_in  = zpc_pkg::PIXEL_W'(zpc_pkg::PIX_MAX);
         saturated_in = 1'b1;
      end else if (rounded < $signed(RES_W'(zpc_pkg::PIX_MIN))) begin
         filtered_in  = zpc_pkg::PIXEL_W'(zpc_pkg::PIX_MIN);
         saturated_in = 1'b1;
      end else begin
         filtered_in  = zpc_pkg::PIXEL_W'(rounded);
         saturated_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= S_IDLE;
         image_width_ff   <= 11'd1024;
         image_height_ff  <= 11'd1024;
         kernel_width_ff  <= 4'd1;
         kernel_height_ff <= 4'd1;
         input_count_ff   <= '0;
         output_count_ff  <= '0;
         wr_ptr_ff        <= '0;
         rd_ptr_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
         p1_ff            <= '0;
         p2_ff            <= '0;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               zpc_pkg::CSR_IMAGE_WIDTH:   image_width_ff   <= csr_bus.data[zpc_pkg::DIM_W-1:0];
               zpc_pkg::CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_bus.data[zpc_pkg::DIM_W-1:0];
               zpc_pkg::CSR_KERNEL_WIDTH:  kernel_width_ff  <= csr_bus.data[zpc_pkg::KDIM_W-1:0];
               zpc_pkg::CSR_KERNEL_HEIGHT: kernel_height_ff <= csr_bus.data[zpc_pkg::KDIM_W-1:0];
               default: ;
            endcase
         end

         rsp_valid_ff <= rsp_valid_in;

         // The tag is registered alongside the store reads in p1, then alongside the multiply in p2.
         p1_ff      <= p1_in;
         p2_ff      <= p1_ff;
         product_ff <= $signed(line_rd) * $signed(coef_rd);
         if (p2_ff.valid && p2_ff.in_image) begin
            acc_ff <= acc_ff + SUM_W'(product_ff);
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (req_bus.mode)
                     zpc_pkg::MODE_PIXEL, zpc_pkg::MODE_FLUSH: begin
                        input_count_ff <= input_count_in;
                        wr_ptr_ff <= (32'(wr_ptr_ff) == LINE_DEPTH - 1) ? '0
                                                                         : wr_ptr_ff + 1'b1;
                        if (emit) begin
                           state_ff   <= S_DIV;
                           dvd_ff     <= output_count_ff;
                           quo_ff     <= '0;
                           remw_ff    <= '0;
                           div_cnt_ff <= '0;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            S_DIV: begin
               dvd_ff     <= dvd_ff << 1;
               quo_ff     <= {quo_ff[zpc_pkg::OUT_COUNT_W-2:0], div_qbit};
               remw_ff    <= remw_in;
               div_cnt_ff <= div_cnt_ff + 1'b1;
               if (div_cnt_ff == DCW'(DIV_STEPS - 1)) begin
                  state_ff <= S_SETUP;
               end
            end
            S_SETUP: begin
               rr_ff        <= $signed(POS_W'(quo_ff)) - $signed(POS_W'(kh_half));
               cc_ff        <= $signed(POS_W'(remw_ff)) - $signed(POS_W'(kw_half));
               c0_ff        <= $signed(POS_W'(remw_ff)) - $signed(POS_W'(kw_half));
               tap_addr_ff  <= start_addr;
               row_ff       <= start_addr;
               i_ff         <= '0;
               j_ff         <= '0;
               coef_addr_ff <= '0;
               acc_ff       <= '0;
               state_ff     <= S_MAC;
            end
            S_MAC: begin
               coef_addr_ff <= coef_addr_ff + 1'b1;
               if (j_ff == kw_eff - 1'b1) begin
                  j_ff        <= '0;
                  i_ff        <= i_ff + 1'b1;
                  rr_ff       <= rr_ff + 1'b1;
                  cc_ff       <= c0_ff;
                  row_ff      <= row_next;
                  tap_addr_ff <= row_next;
               end else begin
                  j_ff        <= j_ff + 1'b1;
                  cc_ff       <= cc_ff + 1'b1;
                  tap_addr_ff <= col_next;
               end
               if (tap_last) begin
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               if (p2_ff.valid && p2_ff.last) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (fin_load) begin
                  filtered_ff  <= filtered_in;
                  saturated_ff <= saturated_in;
                  last_ff      <= frame_last;
                  if (frame_last) begin
                     input_count_ff  <= '0;
                     output_count_ff <= '0;
                     wr_ptr_ff       <= '0;
                     rd_ptr_ff       <= '0;
                  end else begin
                     output_count_ff <= output_count_ff + 1'b1;
                     rd_ptr_ff <= (32'(rd_ptr_ff) == LINE_DEPTH - 1) ? '0
                                                                      : rd_ptr_ff + 1'b1;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.filtered_value = filtered_ff;
   assign rsp_bus.saturated      = saturated_ff;
   assign rsp_bus.last_of_frame  = last_ff;

endmodule

[hdl/zpc_checker.sv]
`timescale 1ns / 1ps

module zpc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic [1:0]                         req_mode,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [zpc_pkg::PIXEL_W-1:0]        rsp_value,
   input logic                               rsp_sat,
   input logic                               rsp_last
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result word dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_value) && $stable(rsp_sat) && $stable(rsp_last))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result word present after reset");

   a_no_result_from_coef: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid &&
      (req_mode == zpc_pkg::MODE_COEF || req_mode == zpc_pkg::MODE_SPARE)
      |=> !rsp_valid)
      else $error("result word raised by a coefficient or spare word");

   a_sat_clips: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_sat |-> (rsp_value == 16'h7FFF || rsp_value == 16'h8000))
      else $error("saturation flag on an unclipped value");

endmodule

bind zero_padded_2d_convolution zpc_checker u_zpc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .req_mode  (req_bus.mode),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.filtered_value),
   .rsp_sat   (rsp_bus.saturated),
   .rsp_last  (rsp_bus.last_of_frame)
);
